// ===== rtl/ldfc_pkg.sv =====
package ldfc_pkg;

   localparam int NUM_CHANNELS_DEF = 8;
   localparam int MAX_LEVEL_DEF    = 100;
   localparam int PWM_W            = 12;
   localparam int LEVEL_IN_W       = 8;
   localparam int CH_W             = 3;
   localparam int MODE_W           = 3;
   localparam logic [PWM_W-1:0] PWM_CAP = 12'd4095;
   localparam logic [3:0]       LOW_FILL = 4'hF;

   localparam logic [7:0] RAMP_STEP_RST    = 8'd20;
   localparam logic [6:0] BLINK_LEVEL_RST  = 7'd60;
   localparam logic [7:0] BLINK_FRAMES_RST = 8'd40;

   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_STEP    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLINK_LEVEL  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLINK_FRAMES = 2'd2;

   typedef enum logic [MODE_W-1:0] {
      MODE_TICK    = 3'd0,
      MODE_SET     = 3'd1,
      MODE_UP      = 3'd2,
      MODE_DOWN    = 3'd3,
      MODE_ENABLE  = 3'd4,
      MODE_TOGGLE  = 3'd5,
      MODE_BLINK   = 3'd6,
      MODE_LIMITS  = 3'd7
   } mode_type;

   typedef struct packed {
      mode_type          mode;
      logic [CH_W-1:0]   channel;
      logic [LEVEL_IN_W-1:0] level;
      logic              on;
      logic [PWM_W-1:0]  min_value;
      logic [PWM_W-1:0]  max_value;
   } cmd_type;

   typedef struct packed {
      logic [7:0] ramp_step;
      logic [6:0] blink_level;
      logic [7:0] blink_frames;
   } cfg_type;

   function automatic logic [7:0] log_rom(input logic [7:0] a);
      logic [7:0] t [256];
      t = '{
      8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h02,8'h02,8'h02,8'h02,8'h03,8'h03,8'h03,8'h04,8'h04,
      8'h04,8'h04,8'h05,8'h05,8'h05,8'h06,8'h06,8'h06,8'h07,8'h07,8'h07,8'h08,8'h08,8'h08,8'h09,8'h09,
      8'h09,8'h0A,8'h0A,8'h0A,8'h0B,8'h0B,8'h0B,8'h0C,8'h0C,8'h0D,8'h0D,8'h0D,8'h0E,8'h0E,8'h0E,8'h0F,
      8'h0F,8'h10,8'h10,8'h10,8'h11,8'h11,8'h12,8'h12,8'h12,8'h13,8'h13,8'h14,8'h14,8'h15,8'h15,8'h16,
      8'h16,8'h16,8'h17,8'h17,8'h18,8'h18,8'h19,8'h19,8'h1A,8'h1A,8'h1B,8'h1B,8'h1C,8'h1C,8'h1D,8'h1D,
      8'h1E,8'h1E,8'h1F,8'h1F,8'h20,8'h21,8'h21,8'h22,8'h22,8'h23,8'h23,8'h24,8'h25,8'h25,8'h26,8'h26,
      8'h27,8'h28,8'h28,8'h29,8'h29,8'h2A,8'h2B,8'h2B,8'h2C,8'h2D,8'h2D,8'h2E,8'h2F,8'h2F,8'h30,8'h31,
      8'h31,8'h32,8'h33,8'h34,8'h34,8'h35,8'h36,8'h37,8'h37,8'h38,8'h39,8'h3A,8'h3A,8'h3B,8'h3C,8'h3D,
      8'h3E,8'h3E,8'h3F,8'h40,8'h41,8'h42,8'h43,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,8'h4A,8'h4B,
      8'h4C,8'h4D,8'h4D,8'h4E,8'h4F,8'h50,8'h51,8'h52,8'h53,8'h54,8'h55,8'h56,8'h57,8'h59,8'h5A,8'h5B,
      8'h5C,8'h5D,8'h5E,8'h5F,8'h60,8'h61,8'h62,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,8'h6B,8'h6C,8'h6D,
      8'h6E,8'h70,8'h71,8'h72,8'h73,8'h75,8'h76,8'h77,8'h79,8'h7A,8'h7B,8'h7D,8'h7E,8'h80,8'h81,8'h82,
      8'h84,8'h85,8'h87,8'h88,8'h8A,8'h8B,8'h8D,8'h8E,8'h90,8'h91,8'h93,8'h95,8'h96,8'h98,8'h9A,8'h9B,
      8'h9D,8'h9E,8'hA0,8'hA2,8'hA4,8'hA5,8'hA7,8'hA9,8'hAB,8'hAC,8'hAE,8'hB0,8'hB2,8'hB4,8'hB6,8'hB8,
      8'hBA,8'hBB,8'hBD,8'hBF,8'hC1,8'hC3,8'hC5,8'hC7,8'hCA,8'hCC,8'hCE,8'hD0,8'hD2,8'hD4,8'hD6,8'hD9,
      8'hDB,8'hDD,8'hDF,8'hE2,8'hE4,8'hE6,8'hE8,8'hEB,8'hED,8'hF0,8'hF2,8'hF4,8'hF7,8'hF9,8'hFC,8'hFF};
      return t[a];
   endfunction

endpackage

// ===== rtl/ldfc_front.sv =====
module ldfc_front #(
   parameter int NUM_CHANNELS = ldfc_pkg::NUM_CHANNELS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  ldfc_pkg::cmd_type in_cmd,
   output logic             q_valid,
   input  logic             q_ready,
   output ldfc_pkg::cmd_type q_cmd
);
   import ldfc_pkg::*;

   localparam int DEPTH = 2;

   cmd_type    mem_ff [DEPTH];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       in_range, push, pop;

   // drop commands to absent channels, ticks always pass
   assign in_range = (in_cmd.mode == MODE_TICK) || (32'(in_cmd.channel) < NUM_CHANNELS);
   assign in_ready = (count_ff != 2'(DEPTH));
   assign push     = in_valid && in_ready && in_range;
   assign q_valid  = (count_ff != 2'd0);
   assign pop      = q_valid && q_ready;
   assign q_cmd    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_cmd;
      end
   end
endmodule

// ===== rtl/ldfc_back.sv =====
module ldfc_back #(
   parameter int NUM_CHANNELS = ldfc_pkg::NUM_CHANNELS_DEF,
   parameter int MAX_LEVEL    = ldfc_pkg::MAX_LEVEL_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  ldfc_pkg::cfg_type  cfg,
   input  logic               q_valid,
   output logic               q_ready,
   input  ldfc_pkg::cmd_type  q_cmd,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [15:0]        rsp_tdata,
   output logic               rsp_tlast
);
   import ldfc_pkg::*;

   localparam int CI_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int LV_W  = $clog2(MAX_LEVEL + 1);
   localparam int RES_CAP = 16;
   localparam logic [LV_W-1:0] MAXL = LV_W'(MAX_LEVEL);
   localparam int RECIP_SH = 20;
   localparam int RECIP    = (2**RECIP_SH + MAX_LEVEL - 1) / MAX_LEVEL;
   localparam logic [PWM_W-1:0] QUOT_RST = PWM_W'((int'(PWM_CAP) - 1) / MAX_LEVEL);

   typedef enum logic [2:0] {
      S_IDLE, S_TGT1, S_TGT2, S_RAMP, S_BLINK, S_EMIT, S_BTGT1, S_BTGT2
   } state_type;

   state_type state_ff;
   logic [LV_W-1:0]  level_ff   [NUM_CHANNELS];
   logic [PWM_W-1:0] cur_ff     [NUM_CHANNELS];
   logic [PWM_W-1:0] min_ff     [NUM_CHANNELS];
   logic [PWM_W-1:0] max_ff     [NUM_CHANNELS];
   logic [PWM_W-1:0] quot_ff    [NUM_CHANNELS];
   logic [7:0]       bcnt_ff    [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] en_ff, bflag_ff;

   logic [CI_W-1:0]  idx_ff;
   logic [4:0]       nres_ff;
   logic             blink_phase_ff;
   logic [LV_W-1:0]  tlvl_ff;
   logic [PWM_W-1:0] lin_ff, tgt_ff;
   logic             o_valid_ff, o_last_ff;
   logic [CH_W-1:0]  o_ch_ff;
   logic [PWM_W-1:0] o_pwm_ff;
   // pending write, waits in S_EMIT
   logic [CH_W-1:0]  p_ch_ff;
   logic [PWM_W-1:0] p_pwm_ff;
   logic             p_last_ff;
   logic             p_drop_ff;
   state_type        ret_ff;
   // deferred write: written to output only once next is known
   logic             hold_ff;
   logic [CH_W-1:0]  h_ch_ff;
   logic [PWM_W-1:0] h_pwm_ff;

   logic [PWM_W-1:0] quot, lo, hi;
   logic [PWM_W-1:0] lim_span, lim_quot;
   logic [31:0]      lim_prod;
   logic [PWM_W-1:0] lin_sum;
   logic [19:0]      prod;
   logic [PWM_W-1:0] lt;
   logic [PWM_W:0]   up, dn;
   logic [PWM_W-1:0] c_cur, c_tgt, nxt;
   logic [7:0]       dec_cnt;
   logic             last_idx;
   logic             out_free;
   logic             o_load;

   // span step of a limits command, by reciprocal multiplication
   assign lim_span = (q_cmd.max_value > q_cmd.min_value)
                     ? q_cmd.max_value - q_cmd.min_value : '0;
   assign lim_prod = 32'(lim_span) * 32'(RECIP);
   assign lim_quot = PWM_W'(lim_prod >> RECIP_SH);

   assign lo = min_ff[idx_ff];
   assign hi = max_ff[idx_ff];
   assign quot = quot_ff[idx_ff];
   assign prod = 20'(tlvl_ff) * 20'(quot + 12'd1);
   assign lin_sum = (prod > 20'(PWM_CAP) || (21'(lo) + 21'(prod)) > 21'(PWM_CAP))
                    ? PWM_CAP : lo + prod[PWM_W-1:0];
   assign lt = {log_rom(lin_ff[11:4]), LOW_FILL};
   assign c_cur = cur_ff[idx_ff];
   assign c_tgt = tgt_ff;
   assign up = 13'(c_cur) + 13'(cfg.ramp_step);
   assign dn = 13'(c_tgt) + 13'(cfg.ramp_step);
   assign nxt = (c_tgt > c_cur) ? ((up <= 13'(c_tgt)) ? up[PWM_W-1:0] : c_tgt)
                : ((13'(c_cur) >= dn) ? c_cur - 12'(cfg.ramp_step) : c_tgt);
   assign dec_cnt = (bcnt_ff[idx_ff] != 8'd0) ? bcnt_ff[idx_ff] - 8'd1 : 8'd0;
   assign last_idx = (32'(idx_ff) == NUM_CHANNELS - 1);
   assign out_free = !o_valid_ff || rsp_tready;
   assign o_load   = out_free && ((state_ff == S_IDLE && hold_ff) ||
                     (state_ff == S_EMIT && !p_drop_ff && (p_last_ff || hold_ff)));

   assign q_ready    = (state_ff == S_IDLE) && !hold_ff;
   assign rsp_tvalid = o_valid_ff;
   assign rsp_tdata  = {1'b0, o_pwm_ff, o_ch_ff};
   assign rsp_tlast  = o_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         en_ff      <= '0;
         bflag_ff   <= '0;
         o_valid_ff <= 1'b0;
         hold_ff    <= 1'b0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            level_ff[i] <= '0;
            cur_ff[i]   <= 12'd1;
            min_ff[i]   <= 12'd1;
            max_ff[i]   <= PWM_CAP;
            quot_ff[i]  <= QUOT_RST;
            bcnt_ff[i]  <= '0;
         end
      end else begin
         if (o_valid_ff && rsp_tready && !o_load) begin
            o_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (q_valid && !hold_ff) begin
                  idx_ff <= (q_cmd.mode == MODE_TICK) ? '0 : CI_W'(q_cmd.channel);
                  case (q_cmd.mode)
                     MODE_TICK: begin
                        nres_ff        <= '0;
                        blink_phase_ff <= 1'b0;
                        state_ff       <= S_TGT1;
                     end
                     MODE_SET: level_ff[CI_W'(q_cmd.channel)] <=
                        (q_cmd.level > 8'(MAX_LEVEL)) ? MAXL : LV_W'(q_cmd.level);
                     MODE_UP: begin
                        if (MAXL - level_ff[CI_W'(q_cmd.channel)] > LV_W'(1))
                           level_ff[CI_W'(q_cmd.channel)] <=
                              level_ff[CI_W'(q_cmd.channel)] + LV_W'(1);
                        else level_ff[CI_W'(q_cmd.channel)] <= MAXL;
                     end
                     MODE_DOWN: begin
                        if (level_ff[CI_W'(q_cmd.channel)] > LV_W'(1))
                           level_ff[CI_W'(q_cmd.channel)] <=
                              level_ff[CI_W'(q_cmd.channel)] - LV_W'(1);
                        else level_ff[CI_W'(q_cmd.channel)] <= '0;
                     end
                     MODE_ENABLE: en_ff[CI_W'(q_cmd.channel)] <= q_cmd.on;
                     MODE_TOGGLE: en_ff[CI_W'(q_cmd.channel)] <=
                        !en_ff[CI_W'(q_cmd.channel)];
                     MODE_BLINK: begin
                        tlvl_ff  <= (cfg.blink_level > 7'(MAX_LEVEL)) ? MAXL
                                    : LV_W'(cfg.blink_level);
                        state_ff <= S_BTGT1;
                     end
                     default: begin
                        min_ff[CI_W'(q_cmd.channel)]  <= q_cmd.min_value;
                        max_ff[CI_W'(q_cmd.channel)]  <= q_cmd.max_value;
                        quot_ff[CI_W'(q_cmd.channel)] <= lim_quot;
                     end
                  endcase
                  if (q_cmd.mode == MODE_TICK) begin
                     tlvl_ff <= level_ff[0];
                  end
               end else if (hold_ff && out_free) begin
                  o_valid_ff <= 1'b1;
                  o_ch_ff    <= h_ch_ff;
                  o_pwm_ff   <= h_pwm_ff;
                  o_last_ff  <= 1'b1;
                  hold_ff    <= 1'b0;
               end
            end
            S_TGT1, S_BTGT1: begin
               lin_ff   <= lin_sum;
               state_ff <= (state_ff == S_TGT1) ? S_TGT2 : S_BTGT2;
            end
            S_BTGT2: begin
               p_ch_ff   <= CH_W'(idx_ff);
               p_pwm_ff  <= (lt > hi) ? hi : lt;
               p_last_ff <= 1'b1;
               p_drop_ff <= 1'b0;
               bflag_ff[idx_ff] <= 1'b1;
               bcnt_ff[idx_ff]  <= cfg.blink_frames;
               ret_ff    <= S_IDLE;
               state_ff  <= S_EMIT;
            end
            S_TGT2: begin
               tgt_ff   <= en_ff[idx_ff] ? ((lt > hi) ? hi : lt) : '0;
               state_ff <= S_RAMP;
            end
            S_RAMP: begin
               if (c_tgt != c_cur) begin
                  cur_ff[idx_ff] <= nxt;
                  p_ch_ff   <= CH_W'(idx_ff);
                  p_pwm_ff  <= nxt;
                  p_last_ff <= 1'b0;
                  p_drop_ff <= (nres_ff >= 5'(RES_CAP));
                  if (nres_ff < 5'(RES_CAP)) nres_ff <= nres_ff + 5'd1;
                  state_ff  <= S_EMIT;
               end else begin
                  state_ff <= last_idx ? S_BLINK : S_TGT1;
               end
               if (last_idx) begin
                  ret_ff <= S_BLINK;
                  idx_ff <= '0;
                  blink_phase_ff <= 1'b1;
               end else begin
                  ret_ff  <= S_TGT1;
                  idx_ff  <= idx_ff + CI_W'(1);
                  tlvl_ff <= level_ff[idx_ff + CI_W'(1)];
               end
            end
            S_BLINK: begin
               if (bflag_ff == '0 && !blink_phase_ff) begin
                  state_ff <= S_IDLE;
               end else if (bflag_ff == '0 && idx_ff == '0) begin
                  state_ff <= S_IDLE;
               end else begin
                  bcnt_ff[idx_ff] <= dec_cnt;
                  if (bflag_ff[idx_ff] && dec_cnt == 8'd0) begin
                     cur_ff[idx_ff]   <= max_ff[idx_ff];
                     bflag_ff[idx_ff] <= 1'b0;
                     p_ch_ff   <= CH_W'(idx_ff);
                     p_pwm_ff  <= max_ff[idx_ff];
                     p_last_ff <= 1'b0;
                     p_drop_ff <= (nres_ff >= 5'(RES_CAP));
                     if (nres_ff < 5'(RES_CAP)) nres_ff <= nres_ff + 5'd1;
                     state_ff  <= S_EMIT;
                     ret_ff    <= last_idx ? S_IDLE : S_BLINK;
                  end else if (last_idx) begin
                     state_ff <= S_IDLE;
                  end
                  blink_phase_ff <= 1'b0;
                  idx_ff <= last_idx ? '0 : idx_ff + CI_W'(1);
               end
            end
            S_EMIT: begin
               // keep one write back so its last flag can be set at the end
               if (p_drop_ff) begin
                  state_ff <= ret_ff;
               end else if (p_last_ff) begin
                  if (out_free) begin
                     o_valid_ff <= 1'b1;
                     o_ch_ff    <= p_ch_ff;
                     o_pwm_ff   <= p_pwm_ff;
                     o_last_ff  <= 1'b1;
                     state_ff   <= ret_ff;
                  end
               end else if (!hold_ff) begin
                  hold_ff  <= 1'b1;
                  h_ch_ff  <= p_ch_ff;
                  h_pwm_ff <= p_pwm_ff;
                  state_ff <= ret_ff;
               end else if (out_free) begin
                  o_valid_ff <= 1'b1;
                  o_ch_ff    <= h_ch_ff;
                  o_pwm_ff   <= h_pwm_ff;
                  o_last_ff  <= 1'b0;
                  h_ch_ff    <= p_ch_ff;
                  h_pwm_ff   <= p_pwm_ff;
                  state_ff   <= ret_ff;
               end
               if (ret_ff == S_BLINK && blink_phase_ff) begin
                  blink_phase_ff <= 1'b1;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ===== rtl/log_dimmer_fade_controller_top.sv =====
// Multichannel LED dimmer with logarithmic fade.
// Commands enter on req_ (mode, channel, level, on, min and max limits); PWM
// writes leave on rsp_ as channel and 12-bit duty, tlast on the final write
// of a command. Only frame ticks and blink commands produce writes.
// csr_ writes ramp_step, blink_level and blink_frames; the user must do so
// only while the block is idle, which the block itself does not enforce.
// A two-entry command queue sits in front of the channel sequencer, so
// commands are taken while the sequencer is busy. State updates are
// registered as the command leaves the queue; a blink write passes through
// the S_BTGT1, S_BTGT2 and S_EMIT states before it reaches rsp_.
// A tick takes each channel through S_TGT1, S_TGT2 and S_RAMP in the ramp
// pass and, when a blink is pending, through S_BLINK in the blink pass, with
// an S_EMIT step per write; a single shared target datapath serves them all.
// Each tick write is held one step back so its tlast can be known; a stalled
// receiver holds the output register and halts the sequencer.
// Reset sets levels to 0, all channels disabled, current and minimum PWM to
// one, maximum PWM to 4095 and clears blinks.
module log_dimmer_fade_controller_top #(
   parameter int NUM_CHANNELS = ldfc_pkg::NUM_CHANNELS_DEF,
   parameter int MAX_LEVEL    = ldfc_pkg::MAX_LEVEL_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // mode[2:0], channel[5:3], level[13:6], on[14], min_value[26:15], max_value[38:27]
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_channel[2:0], pwm_value[14:3]
   output logic [15:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [ldfc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ldfc_pkg::CSR_DAT_W-1:0] csr_wdata
);
   import ldfc_pkg::*;

   cmd_type cmd, q_cmd;
   cfg_type cfg_ff;
   logic    q_valid, q_ready;

   assign cmd.mode      = mode_type'(req_tdata[2:0]);
   assign cmd.channel   = req_tdata[5:3];
   assign cmd.level     = req_tdata[13:6];
   assign cmd.on        = req_tdata[14];
   assign cmd.min_value = req_tdata[26:15];
   assign cmd.max_value = req_tdata[38:27];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ramp_step    <= RAMP_STEP_RST;
         cfg_ff.blink_level  <= BLINK_LEVEL_RST;
         cfg_ff.blink_frames <= BLINK_FRAMES_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RAMP_STEP:    cfg_ff.ramp_step    <= csr_wdata;
            CSR_BLINK_LEVEL:  cfg_ff.blink_level  <= csr_wdata[6:0];
            CSR_BLINK_FRAMES: cfg_ff.blink_frames <= csr_wdata;
            default: ;
         endcase
      end
   end

   ldfc_front #(.NUM_CHANNELS(NUM_CHANNELS)) u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_cmd(cmd),
      .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
   );

   ldfc_back #(.NUM_CHANNELS(NUM_CHANNELS), .MAX_LEVEL(MAX_LEVEL)) u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );
endmodule

// ===== rtl/ldfc_checker.sv =====
module ldfc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("response changed under stall");
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[15] == 1'b0)
      else $error("response padding set");
   a_rst: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");
endmodule

bind log_dimmer_fade_controller_top ldfc_checker u_checker (
   .clock(clock), .reset(reset), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
);

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import ldfc_pkg::*;

   typedef struct {
      logic [2:0]  chan;
      logic [11:0] duty;
      logic        fin;
   } pwm_write_type;

   class fade_scoreboard;
      byte unsigned curve[256];
      int unsigned  step_size;
      int unsigned  blink_pct;
      int unsigned  blink_ticks;
      int unsigned  lvl[8];
      int unsigned  cur[8];
      int unsigned  lo[8];
      int unsigned  hi[8];
      int unsigned  blink_cnt[8];
      logic [7:0]   en_mask;
      logic [7:0]   blink_mask;
      pwm_write_type pending_writes[$];
      int           errors;
      int           writes_seen;
      int           ticks_seen;

      function new();
         curve = '{
         1,1,1,1,1,1,1,2,2,2,2,3,3,3,4,4,4,4,5,5,
         5,6,6,6,7,7,7,8,8,8,9,9,9,10,10,10,11,11,11,12,
         12,13,13,13,14,14,14,15,15,16,16,16,17,17,18,18,18,19,19,20,
         20,21,21,22,22,22,23,23,24,24,25,25,26,26,27,27,28,28,29,29,
         30,30,31,31,32,33,33,34,34,35,35,36,37,37,38,38,39,40,40,41,
         41,42,43,43,44,45,45,46,47,47,48,49,49,50,51,52,52,53,54,55,
         55,56,57,58,58,59,60,61,62,62,63,64,65,66,67,67,68,69,70,71,
         72,73,74,75,76,77,77,78,79,80,81,82,83,84,85,86,87,89,90,91,
         92,93,94,95,96,97,98,100,101,102,103,104,105,107,108,109,110,112,113,114,
         115,117,118,119,121,122,123,125,126,128,129,130,132,133,135,136,138,139,141,142,
         144,145,147,149,150,152,154,155,157,158,160,162,164,165,167,169,171,172,174,176,
         178,180,182,184,186,187,189,191,193,195,197,199,202,204,206,208,210,212,214,217,
         219,221,223,226,228,230,232,235,237,240,242,244,247,249,252,255};
         step_size = 20;
         blink_pct = 60;
         blink_ticks = 40;
         en_mask = '0;
         blink_mask = '0;
         for (int c = 0; c < 8; c++) begin
            lvl[c] = 0;
            cur[c] = 1;
            lo[c] = 1;
            hi[c] = 4095;
            blink_cnt[c] = 0;
         end
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [7:0] val);
         case (idx)
            CSR_RAMP_STEP:    step_size = 32'(val);
            CSR_BLINK_LEVEL:  blink_pct = 32'(val[6:0]);
            CSR_BLINK_FRAMES: blink_ticks = 32'(val);
            default: ;
         endcase
      endfunction

      function int unsigned target(int c, int unsigned pct);
         int unsigned span;
         int unsigned lin;
         int unsigned t;
         span = (hi[c] > lo[c]) ? hi[c] - lo[c] : 0;
         if (pct > 100) pct = 100;
         lin = lo[c] + pct * (span / 100 + 1);
         if (lin > 4095) lin = 4095;
         t = (curve[lin >> 4] << 4) | 4'hF;
         if (t > hi[c]) t = hi[c];
         return t;
      endfunction

      function void push(int c, int unsigned v);
         pwm_write_type w;
         w.chan = c[2:0];
         w.duty = v[11:0];
         w.fin = 1'b0;
         pending_writes.push_back(w);
      endfunction

      function void note_command(logic [39:0] d);
         mode_type    m;
         int          ch;
         int unsigned t;
         int          first;
         m = mode_type'(d[2:0]);
         ch = 32'(d[5:3]);
         first = pending_writes.size();
         case (m)
            MODE_TICK: begin
               ticks_seen++;
               for (int c = 0; c < 8; c++) begin
                  t = en_mask[c] ? target(c, lvl[c]) : 0;
                  if (t != cur[c]) begin
                     if (t > cur[c])
                        cur[c] = (cur[c] + step_size <= t) ? cur[c] + step_size : t;
                     else
                        cur[c] = (cur[c] >= t + step_size) ? cur[c] - step_size : t;
                     push(c, cur[c]);
                  end
               end
               if (blink_mask != 0) begin
                  for (int c = 0; c < 8; c++) begin
                     if (blink_cnt[c] > 0) blink_cnt[c]--;
                     if (blink_mask[c] && blink_cnt[c] == 0) begin
                        cur[c] = hi[c];
                        blink_mask[c] = 1'b0;
                        push(c, hi[c]);
                     end
                  end
               end
            end
            MODE_SET:    lvl[ch] = (d[13:6] > 100) ? 100 : 32'(d[13:6]);
            MODE_UP:     lvl[ch] = (100 - lvl[ch] > 1) ? lvl[ch] + 1 : 100;
            MODE_DOWN:   lvl[ch] = (lvl[ch] > 1) ? lvl[ch] - 1 : 0;
            MODE_ENABLE: en_mask[ch] = d[14];
            MODE_TOGGLE: en_mask[ch] = ~en_mask[ch];
            MODE_BLINK: begin
               push(ch, target(ch, blink_pct));
               blink_mask[ch] = 1'b1;
               blink_cnt[ch] = blink_ticks;
            end
            default: begin
               lo[ch] = 32'(d[26:15]);
               hi[ch] = 32'(d[38:27]);
            end
         endcase
         if (pending_writes.size() > first)
            pending_writes[pending_writes.size()-1].fin = 1'b1;
      endfunction

      task report(string what);
         $display("[%0t] MISMATCH %s", $realtime, what);
         errors++;
      endtask

      task check_write(logic [2:0] c, logic [11:0] v, logic l);
         pwm_write_type w;
         writes_seen++;
         if (pending_writes.size() == 0) begin
            report($sformatf("unexpected write ch %0d pwm %0d last %0b", c, v, l));
         end else begin
            w = pending_writes.pop_front();
            if (c !== w.chan) report($sformatf("channel %0d, want %0d", c, w.chan));
            if (v !== w.duty) report($sformatf("pwm %0d, want %0d", v, w.duty));
            if (l !== w.fin) report($sformatf("last %0b, want %0b", l, w.fin));
         end
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_wdata;

   fade_scoreboard sb;
   int  sent;
   bit  idle_on;
   bit  rsp_hold;
   int  rsp_wait;

   log_dimmer_fade_controller_top i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task send_cmd(mode_type m, int ch, int lv, bit on, int mn, int mx);
      logic [39:0] d;
      int          gap;
      d = {1'b0, mx[11:0], mn[11:0], on, lv[7:0], ch[2:0], m};
      gap = idle_on ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
      sb.note_command(d);
      sent++;
   endtask

   task drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending_writes.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task write_reg(logic [CSR_IDX_W-1:0] idx, logic [7:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      sb.set_reg(idx, val);
   endtask

   task set_regs(int rs, int bl, int bf);
      write_reg(CSR_RAMP_STEP, 8'(rs));
      write_reg(CSR_BLINK_LEVEL, 8'(bl));
      write_reg(CSR_BLINK_FRAMES, 8'(bf));
   endtask

   task random_cmd();
      int r;
      int mn;
      int mx;
      r = $urandom_range(0, 99);
      mn = $urandom_range(0, 1) ? $urandom_range(0, 4095) : $urandom_range(0, 200);
      mx = $urandom_range(0, 1) ? $urandom_range(0, 4095) : $urandom_range(3800, 4095);
      send_cmd(r < 35 ? MODE_TICK : r < 45 ? MODE_SET : r < 52 ? MODE_UP :
               r < 58 ? MODE_DOWN : r < 70 ? MODE_ENABLE : r < 74 ? MODE_TOGGLE :
               r < 82 ? MODE_BLINK : MODE_LIMITS,
               $urandom_range(0, 7),
               $urandom_range(0, 3) != 0 ? $urandom_range(0, 100) : $urandom_range(0, 255),
               $urandom_range(0, 3) != 0, mn, mx);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_write(rsp_tdata[2:0], rsp_tdata[14:3], rsp_tlast);
         rsp_wait = $urandom_range(0, 1) ? $urandom_range(0, 12) : 0;
      end
   end

   always @(negedge clock) begin
      if (rsp_wait > 0) begin
         rsp_wait--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !rsp_hold;
      end
   end

   initial begin
      while (sent < 150) @(posedge clock);
      rsp_hold = 1'b1;
      repeat (400) @(posedge clock);
      rsp_hold = 1'b0;
   end

   initial begin
      #5ms;
      $display("log_dimmer_fade_controller_top test failed");
      $finish;
   end

   initial begin
      int cfg[4][3];
      sb = new();
      sent = 0;
      idle_on = 1'b0;
      rsp_hold = 1'b0;
      rsp_wait = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (4) @(posedge clock);

      // directed: clamps, saturation, inverted limits, blink expiry
      set_regs(255, 100, 1);
      send_cmd(MODE_SET, 0, 255, 0, 0, 0);
      send_cmd(MODE_ENABLE, 0, 0, 1, 0, 0);
      send_cmd(MODE_TICK, 0, 0, 0, 0, 0);
      send_cmd(MODE_TICK, 7, 255, 1, 4095, 4095);
      send_cmd(MODE_UP, 0, 0, 0, 0, 0);
      send_cmd(MODE_DOWN, 1, 0, 0, 0, 0);
      send_cmd(MODE_SET, 2, 100, 0, 0, 0);
      send_cmd(MODE_UP, 2, 0, 0, 0, 0);
      send_cmd(MODE_TOGGLE, 2, 0, 0, 0, 0);
      send_cmd(MODE_LIMITS, 3, 0, 0, 4095, 0);
      send_cmd(MODE_ENABLE, 3, 0, 1, 0, 0);
      send_cmd(MODE_SET, 3, 50, 0, 0, 0);
      send_cmd(MODE_TICK, 0, 0, 0, 0, 0);
      send_cmd(MODE_LIMITS, 4, 0, 0, 0, 4095);
      send_cmd(MODE_ENABLE, 4, 0, 1, 0, 0);
      send_cmd(MODE_BLINK, 5, 0, 0, 0, 0);
      send_cmd(MODE_TICK, 0, 0, 0, 0, 0);
      send_cmd(MODE_BLINK, 6, 0, 0, 0, 0);
      send_cmd(MODE_LIMITS, 7, 255, 1, 4095, 4095);
      send_cmd(MODE_TICK, 0, 0, 0, 0, 0);
      send_cmd(MODE_DOWN, 0, 0, 0, 0, 0);
      send_cmd(MODE_ENABLE, 0, 0, 0, 0, 0);
      send_cmd(MODE_TICK, 0, 0, 0, 0, 0);
      send_cmd(MODE_TOGGLE, 2, 0, 0, 0, 0);
      send_cmd(MODE_TICK, 0, 0, 0, 0, 0);
      drain();

      cfg = '{'{20, 60, 40}, '{1, 0, 255}, '{255, 127, 3}, '{7, 33, 10}};
      for (int p = 0; p < 4; p++) begin
         set_regs(cfg[p][0], cfg[p][1], cfg[p][2]);
         for (int i = 0; i < 72; i++) begin
            if (i % 18 == 0) idle_on = $urandom_range(0, 2) != 0;
            random_cmd();
         end
         drain();
      end

      $display("covered %0d commands, %0d frame ticks, %0d pwm writes, 5 register sets",
               sent, sb.ticks_seen, sb.writes_seen);
      if (sb.errors == 0 && sb.pending_writes.size() == 0) begin
         $display("log_dimmer_fade_controller_top test passed");
      end else begin
         $display("log_dimmer_fade_controller_top test failed");
      end
      $finish;
   end

endmodule

// ===== log_dimmer_fade_controller_top.f =====
rtl/ldfc_pkg.sv
rtl/ldfc_front.sv
rtl/ldfc_back.sv
rtl/log_dimmer_fade_controller_top.sv
rtl/ldfc_checker.sv
dv/tb.sv
